[rtl/core/lfsm_pkg.sv]
// Shared types and constants for the latest-frame slot manager.
// Holds item payload structs, event codes and fixed field widths.
// No dependencies.
package lfsm_pkg;

  localparam int FIELD_W    = 32;  // width of fence fields on the ports
  localparam int SLOT_IDX_W = 3;   // width of the slot index on the ports
  localparam int MODE_W     = 2;
  localparam int CFG_W      = 4;   // width of the slot count write data
  localparam int MIN_SLOTS  = 2;
  localparam int RST_SLOTS  = 3;

  // Event codes; the fourth code is unused and yields an all-zero result.
  localparam logic [MODE_W-1:0] MODE_PROD_BEGIN = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PROD_END   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CONS_BEGIN = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [FIELD_W-1:0] producer_done;
    logic [FIELD_W-1:0] consumer_done;
  } req_item_t;

  typedef struct packed {
    logic [SLOT_IDX_W-1:0] slot_index;
    logic                  frame_ready;
    logic                  wait_needed;
    logic [FIELD_W-1:0]    wait_value;
    logic [FIELD_W-1:0]    signal_value;
  } rsp_item_t;

endpackage

[rtl/core/lfsm_req_if.sv]
// Event channel into the slot manager: valid/ready handshake plus payload.
// Depends on lfsm_pkg for the payload struct.
interface lfsm_req_if;
  logic                  valid;
  logic                  ready;
  lfsm_pkg::req_item_t   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/lfsm_rsp_if.sv]
// Result channel out of the slot manager: valid/ready handshake plus payload.
// Depends on lfsm_pkg for the payload struct.
interface lfsm_rsp_if;
  logic                  valid;
  logic                  ready;
  lfsm_pkg::rsp_item_t   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/latest_frame_slot_manager_core.sv]
// Latest-frame slot manager: ring of frame slots for one producer and one consumer.
// Depends on lfsm_pkg, lfsm_req_if and lfsm_rsp_if.
//
//   channel   dir  handshake        payload
//   req       in   valid/ready      mode, producer_done, consumer_done
//   rsp       out  valid/ready      slot_index, frame_ready, wait_needed,
//                                   wait_value, signal_value
//   cfg       in   cfg_wr_en only   cfg_wr_data (slot count)
//
// One item at a time. Producer begin runs S_PB then S_PUSH, producer end S_PE1,
// S_PE2 if needed, then S_PUSH; consumer begin goes to S_PUSH (no frame yet) or
// to S_CB_FIN, after any consumer skip walk in S_CB_WALK, one slot per cycle,
// through the single read port of the producer stamp memory. S_PUSH loads the
// output register; the cycle after the load is idle again and accepts the next item.
// A result waiting in the output register does not block the next accept; only
// the final push stalls until that register is free.
// rst is synchronous and active high; it clears control state and all stamp
// valid bits, so no clearing pass is needed. A slot count write reinitializes
// the ring pointers, consumer count and stamp valid bits the same way.
module latest_frame_slot_manager_core #(
  parameter int MAX_SLOTS  = 8,
  parameter int FENCE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [lfsm_pkg::CFG_W-1:0]   cfg_wr_data,
  lfsm_req_if.sink                     req,
  lfsm_rsp_if.source                   rsp
);

  localparam int SLOT_W = $clog2(MAX_SLOTS);
  localparam int CNT_W  = SLOT_W + 1;
  localparam int RST_COUNT =
    (lfsm_pkg::RST_SLOTS > MAX_SLOTS) ? MAX_SLOTS : lfsm_pkg::RST_SLOTS;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_PB      = 7'b0000010,
    S_PE1     = 7'b0000100,
    S_PE2     = 7'b0001000,
    S_CB_WALK = 7'b0010000,
    S_CB_FIN  = 7'b0100000,
    S_PUSH    = 7'b1000000
  } state_t;

  typedef logic [SLOT_W-1:0]     slot_t;
  typedef logic [FENCE_BITS-1:0] fence_t;

  // Step one slot forward around the ring of n_slots entries.
  function automatic slot_t next_slot(input slot_t s, input logic [CNT_W-1:0] n_slots);
    logic [CNT_W-1:0] n;
    n = CNT_W'(s) + CNT_W'(1);
    return (n >= n_slots) ? '0 : n[SLOT_W-1:0];
  endfunction

  state_t                state, state_next;
  logic [CNT_W-1:0]      slot_count;
  slot_t                 pslot, pslot_next;
  slot_t                 cslot, cslot_next;
  fence_t                ccount, ccount_next;
  fence_t                pcur, pcur_next;
  fence_t                pdone_q, cdone_q;
  lfsm_pkg::rsp_item_t   res, res_next;
  lfsm_pkg::rsp_item_t   out_data;
  logic                  out_valid;
  logic                  accept;
  logic                  out_load;
  logic [CNT_W-1:0]      cfg_count;
  slot_t                 pnext, cnext;
  fence_t                cinc;
  fence_t                req_pdone;

  // Stamp memories: one read port and one write port each, registered reads.
  fence_t                pst_mem [MAX_SLOTS];
  fence_t                cst_mem [MAX_SLOTS];
  logic [MAX_SLOTS-1:0]  pst_vld, cst_vld;
  fence_t                pst_q, cst_q;
  logic                  pst_vq, cst_vq;
  fence_t                pst_val, cst_val;
  logic                  pst_rd_en, cst_rd_en;
  slot_t                 pst_raddr, cst_raddr;
  logic                  pst_we, cst_we;
  slot_t                 pst_waddr, cst_waddr;
  fence_t                pst_wdata, cst_wdata;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;
  assign out_load  = (state == S_PUSH) && (!out_valid || rsp.ready);

  assign pnext     = next_slot(pslot, slot_count);
  assign cnext     = next_slot(cslot, slot_count);
  assign cinc      = ccount + FENCE_BITS'(1);
  assign req_pdone = FENCE_BITS'(req.data.producer_done);

  // Entries never written since reset or reconfiguration read as zero.
  assign pst_val = pst_vq ? pst_q : '0;
  assign cst_val = cst_vq ? cst_q : '0;

  // Clamp the written slot count into the supported range.
  always_comb begin
    if (int'(cfg_wr_data) < lfsm_pkg::MIN_SLOTS) begin
      cfg_count = CNT_W'(lfsm_pkg::MIN_SLOTS);
    end else if (int'(cfg_wr_data) > MAX_SLOTS) begin
      cfg_count = CNT_W'(MAX_SLOTS);
    end else begin
      cfg_count = CNT_W'(cfg_wr_data);
    end
  end

  always_comb begin
    state_next  = state;
    pslot_next  = pslot;
    cslot_next  = cslot;
    ccount_next = ccount;
    pcur_next   = pcur;
    res_next    = res;
    pst_rd_en   = 1'b0;
    pst_raddr   = pslot;
    cst_rd_en   = 1'b0;
    cst_raddr   = pslot;
    pst_we      = 1'b0;
    pst_waddr   = pnext;
    pst_wdata   = pcur + FENCE_BITS'(1);
    cst_we      = 1'b0;
    cst_waddr   = cslot;
    cst_wdata   = cinc;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (req.data.mode)
            lfsm_pkg::MODE_PROD_BEGIN: begin
              cst_rd_en  = 1'b1;
              cst_raddr  = pslot;
              state_next = S_PB;
            end
            lfsm_pkg::MODE_PROD_END: begin
              pst_rd_en  = 1'b1;
              pst_raddr  = pslot;
              state_next = S_PE1;
            end
            lfsm_pkg::MODE_CONS_BEGIN: begin
              if (cslot == pslot) begin
                state_next = S_CB_FIN;
              end else if (req_pdone == '0) begin
                // Nothing completed yet: report no frame, touch no state.
                res_next            = '0;
                res_next.slot_index = lfsm_pkg::SLOT_IDX_W'(cslot);
                state_next          = S_PUSH;
              end else begin
                pst_rd_en  = 1'b1;
                pst_raddr  = cnext;
                state_next = S_CB_WALK;
              end
            end
            default: begin
              res_next   = '0;
              state_next = S_PUSH;
            end
          endcase
        end
      end

      S_PB: begin
        res_next             = '0;
        res_next.slot_index  = lfsm_pkg::SLOT_IDX_W'(pslot);
        res_next.frame_ready = 1'b1;
        if (cdone_q < cst_val) begin
          res_next.wait_needed = 1'b1;
          res_next.wait_value  = lfsm_pkg::FIELD_W'(cst_val);
        end
        state_next = S_PUSH;
      end

      S_PE1: begin
        pcur_next             = pst_val;
        res_next              = '0;
        res_next.slot_index   = lfsm_pkg::SLOT_IDX_W'(pslot);
        res_next.frame_ready  = 1'b1;
        res_next.signal_value = lfsm_pkg::FIELD_W'(pst_val);
        if (pnext == cslot) begin
          // Producer would land on the consumer: fetch the stamp one past it.
          pst_rd_en  = 1'b1;
          pst_raddr  = cnext;
          state_next = S_PE2;
        end else begin
          pst_we     = 1'b1;
          pst_wdata  = pst_val + FENCE_BITS'(1);
          pslot_next = pnext;
          state_next = S_PUSH;
        end
      end

      S_PE2: begin
        // Push the consumer ahead, then advance and stamp the producer.
        if (pdone_q < pst_val) begin
          res_next.wait_needed = 1'b1;
          res_next.wait_value  = lfsm_pkg::FIELD_W'(pst_val);
        end
        cslot_next = cnext;
        pst_we     = 1'b1;
        pslot_next = pnext;
        state_next = S_PUSH;
      end

      S_CB_WALK: begin
        // Advance while the next slot is complete, stop at the producer.
        if (pdone_q < pst_val) begin
          state_next = S_CB_FIN;
        end else begin
          cslot_next = cnext;
          if (cnext == pslot) begin
            state_next = S_CB_FIN;
          end else begin
            pst_rd_en = 1'b1;
            pst_raddr = next_slot(cnext, slot_count);
          end
        end
      end

      S_CB_FIN: begin
        ccount_next           = cinc;
        cst_we                = 1'b1;
        res_next              = '0;
        res_next.slot_index   = lfsm_pkg::SLOT_IDX_W'(cslot);
        res_next.frame_ready  = 1'b1;
        res_next.signal_value = lfsm_pkg::FIELD_W'(cinc);
        state_next            = S_PUSH;
      end

      S_PUSH: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state; a slot count write reinitializes the ring.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      slot_count <= CNT_W'(RST_COUNT);
      pslot      <= '0;
      cslot      <= SLOT_W'(RST_COUNT - 1);
      ccount     <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        slot_count <= cfg_count;
        pslot      <= '0;
        cslot      <= SLOT_W'(cfg_count - CNT_W'(1));
        ccount     <= '0;
      end else begin
        pslot  <= pslot_next;
        cslot  <= cslot_next;
        ccount <= ccount_next;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers: hold the event operands and the pending result.
  always_ff @(posedge clk) begin
    if (accept) begin
      pdone_q <= req_pdone;
      cdone_q <= FENCE_BITS'(req.data.consumer_done);
    end
    pcur <= pcur_next;
    res  <= res_next;
    if (out_load) begin
      out_data <= res;
    end
  end

  // Stamp valid bits: clear on reset and reconfiguration, set on write.
  always_ff @(posedge clk) begin
    if (rst || cfg_wr_en) begin
      pst_vld <= '0;
      cst_vld <= '0;
    end else begin
      if (pst_we) begin
        pst_vld[pst_waddr] <= 1'b1;
      end
      if (cst_we) begin
        cst_vld[cst_waddr] <= 1'b1;
      end
    end
  end

  // Producer stamp memory.
  always_ff @(posedge clk) begin
    if (pst_we) begin
      pst_mem[pst_waddr] <= pst_wdata;
    end
    if (pst_rd_en) begin
      pst_q  <= pst_mem[pst_raddr];
      pst_vq <= pst_vld[pst_raddr];
    end
  end

  // Consumer stamp memory.
  always_ff @(posedge clk) begin
    if (cst_we) begin
      cst_mem[cst_waddr] <= cst_wdata;
    end
    if (cst_rd_en) begin
      cst_q  <= cst_mem[cst_raddr];
      cst_vq <= cst_vld[cst_raddr];
    end
  end

endmodule
